// File: rtl/core/fsp_pkg.sv
// Shared types and constants for the flow stencil propagation block.
package fsp_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
  localparam int RL_W           = 11;
  localparam int DATA_W         = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Divide by five of a 34-bit magnitude: split at bit 17 and use two exact
  // reciprocal multiplies (floor(x * ceil(2^k / 5) / 2^k) for narrow x).
  localparam int            SPLIT_W     = 17;
  localparam logic [17:0]   DIV5_HI_MUL = 18'd209716;   // ceil(2^20 / 5)
  localparam int            DIV5_HI_SH  = 20;
  localparam logic [20:0]   DIV5_LO_MUL = 21'd1677722;  // ceil(2^23 / 5)
  localparam int            DIV5_LO_SH  = 23;

  // How a cell is handled by the back end.
  typedef enum logic [1:0] {
    K_PASS  = 2'd0,  // first row or particle: value kept
    K_LEFT  = 2'd1,  // left edge, divide by four
    K_RIGHT = 2'd2,  // right edge, divide by four
    K_MID   = 2'd3   // interior, divide by five
  } kind_t;

  // Request handed from the front end to the back end.
  typedef struct packed {
    logic [DATA_W-1:0] cell_val;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] up_left;
    logic [DATA_W-1:0] up_right;
    kind_t             kind;
    logic              frame_start;
    logic              row_end;
  } entry_t;

  // Per-request control carried along the back-end pipeline.
  typedef struct packed {
    logic [DATA_W-1:0] cell_val;
    kind_t             kind;
    logic              frame_start;
    logic              row_end;
  } ctl_t;

endpackage

// File: rtl/core/fsp_front.sv
// Front end: column tracking, cell classification and the upper-row line store.
module fsp_front import fsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RL_W-1:0]   row_length,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] cell_value,
  input  logic              has_particle,
  input  logic              frame_start,
  output logic              push_valid,
  input  logic              push_ready,
  output entry_t            push_entry
);

  logic [DATA_W-1:0] line_mem [MAX_ROW_LENGTH];

  logic [COL_W-1:0]  col_r, col_nxt;
  logic              first_r, first_nxt;
  logic [DATA_W-1:0] up_rd_r, ur_rd_r, ul_r;
  logic              b_valid_r, b_valid_nxt;
  logic [DATA_W-1:0] b_cell_r;
  kind_t             b_kind_r;
  logic              b_fs_r;
  logic              b_end_r;

  logic [RL_W-1:0]   rl_clamp;
  logic [RL_W-1:0]   last_full;
  logic [COL_W-1:0]  last_col;
  logic [COL_W-1:0]  start_col;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_inc;
  logic              first;
  logic              is_last;
  logic              accept;
  kind_t             kind;

  always_comb begin
    if (row_length < RL_W'(2)) begin
      rl_clamp = RL_W'(2);
    end else if (row_length > RL_W'(MAX_ROW_LENGTH)) begin
      rl_clamp = RL_W'(MAX_ROW_LENGTH);
    end else begin
      rl_clamp = row_length;
    end
    last_full = rl_clamp - RL_W'(1);
    last_col  = last_full[COL_W-1:0];

    start_col = frame_start ? '0 : col_r;
    first     = frame_start | first_r;
    // A position beyond a shortened row is handled as the row's last cell.
    col       = (start_col > last_col) ? last_col : start_col;
    col_inc   = col + COL_W'(1);
    is_last   = (col == last_col);

    if (first || has_particle) begin
      kind = K_PASS;
    end else if (col == '0) begin
      kind = K_LEFT;
    end else if (is_last) begin
      kind = K_RIGHT;
    end else begin
      kind = K_MID;
    end

    col_nxt   = is_last ? '0 : col_inc;
    first_nxt = is_last ? 1'b0 : first;
  end

  assign in_ready = !b_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (push_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      first_r   <= 1'b1;
      b_valid_r <= 1'b0;
      ul_r      <= '0;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (accept) begin
        col_r   <= col_nxt;
        first_r <= first_nxt;
      end
      // The up-left tap is the previous cell's up tap, taken in stream order.
      if (push_valid && push_ready) begin
        ul_r <= up_rd_r;
      end
    end
  end

  // The reads return the row above; the write replaces it with this row.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col] <= cell_value;
      up_rd_r       <= line_mem[col];
      ur_rd_r       <= line_mem[col_inc];
      b_cell_r      <= cell_value;
      b_kind_r      <= kind;
      b_fs_r        <= frame_start;
      b_end_r       <= is_last;
    end
  end

  assign push_valid = b_valid_r;

  always_comb begin
    push_entry.cell_val    = b_cell_r;
    push_entry.up          = up_rd_r;
    push_entry.up_left     = ul_r;
    push_entry.up_right    = ur_rd_r;
    push_entry.kind        = b_kind_r;
    push_entry.frame_start = b_fs_r;
    push_entry.row_end     = b_end_r;
  end

endmodule

// File: rtl/core/fsp_queue.sv
// Short request queue between the front end and the back end.
module fsp_queue import fsp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  entry_t in_entry,
  output logic   out_valid,
  input  logic   out_ready,
  output entry_t out_entry
);

  entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign in_ready  = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_entry;
    end
  end

endmodule

// File: rtl/core/fsp_back.sv
// Back end: stencil sum, constant divide, variation and running maximum.
module fsp_back import fsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  entry_t            pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] new_value,
  output logic [DATA_W-1:0] variation,
  output logic [DATA_W-1:0] max_variation,
  output logic              updated,
  output logic              row_end
);

  localparam int NSTAGE = 9;

  logic              v_r   [1:NSTAGE];
  ctl_t              ctl_r [1:NSTAGE];
  logic              en;

  logic signed [33:0] p1_r;
  logic signed [32:0] n1_r;
  logic signed [34:0] sum2_r;
  logic [33:0]        mag3_r, mag4_r;
  logic               neg3_r, neg4_r, neg5_r, neg6_r;
  logic [14:0]        qa4_r, qa5_r, qa6_r;
  logic [DATA_W-1:0]  q4_4_r, q4_5_r, q4_6_r;
  logic [19:0]        x5_r;
  logic [16:0]        qb6_r;
  logic [DATA_W-1:0]  new7_r, new8_r, out_new_r;
  logic [DATA_W-1:0]  var8_r, out_var_r;
  logic [DATA_W-1:0]  max_r, max_nxt;

  logic signed [33:0] p1;
  logic signed [32:0] n1;
  logic [33:0]        mag3;
  logic [34:0]        prod_hi;
  logic [16:0]        rem_full;
  logic [40:0]        prod_lo;
  logic [DATA_W-1:0]  quot;
  logic [DATA_W-1:0]  new7;
  logic [32:0]        diff;
  logic [32:0]        diff_abs;
  logic [DATA_W-1:0]  max_base;

  // The whole pipeline stalls together behind the output register.
  assign en        = !v_r[NSTAGE] || out_ready;
  assign pop_ready = en;

  always_comb begin
    p1 = {{2{pop_entry.cell_val[31]}}, pop_entry.cell_val}
       + {pop_entry.up[31], pop_entry.up, 1'b0};
    n1 = ((pop_entry.kind == K_LEFT) ? 33'sd0
          : {pop_entry.up_left[31], pop_entry.up_left})
       + ((pop_entry.kind == K_RIGHT) ? 33'sd0
          : {pop_entry.up_right[31], pop_entry.up_right});

    mag3 = sum2_r[34] ? 34'(-sum2_r) : sum2_r[33:0];

    prod_hi  = 35'(mag3_r[33:SPLIT_W]) * 35'(DIV5_HI_MUL);
    rem_full = mag4_r[33:SPLIT_W] - 17'(qa4_r * 17'd5);
    prod_lo  = 41'(x5_r) * 41'(DIV5_LO_MUL);

    // The high and low quotients do not overlap, so they simply concatenate.
    quot = (ctl_r[6].kind == K_MID) ? {qa6_r, qb6_r} : q4_6_r;
    if (ctl_r[6].kind == K_PASS) begin
      new7 = ctl_r[6].cell_val;
    end else begin
      new7 = neg6_r ? (-quot) : quot;
    end

    diff     = {ctl_r[7].cell_val[31], ctl_r[7].cell_val} - {new7_r[31], new7_r};
    diff_abs = diff[32] ? (-diff) : diff;

    max_base = ctl_r[8].frame_start ? '0 : max_r;
    max_nxt  = (var8_r > max_base) ? var8_r : max_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= NSTAGE; i++) begin
        v_r[i] <= 1'b0;
      end
      max_r <= '0;
    end else if (en) begin
      v_r[1] <= pop_valid;
      for (int i = 2; i <= NSTAGE; i++) begin
        v_r[i] <= v_r[i-1];
      end
      if (v_r[NSTAGE-1]) begin
        max_r <= max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[1].cell_val    <= pop_entry.cell_val;
      ctl_r[1].kind        <= pop_entry.kind;
      ctl_r[1].frame_start <= pop_entry.frame_start;
      ctl_r[1].row_end     <= pop_entry.row_end;
      for (int i = 2; i <= NSTAGE; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end

      p1_r      <= p1;
      n1_r      <= n1;
      sum2_r    <= {p1_r[33], p1_r} + {{2{n1_r[32]}}, n1_r};
      mag3_r    <= mag3;
      neg3_r    <= sum2_r[34];
      mag4_r    <= mag3_r;
      neg4_r    <= neg3_r;
      q4_4_r    <= mag3_r[33:2];
      qa4_r     <= prod_hi[34:DIV5_HI_SH];
      x5_r      <= {rem_full[2:0], mag4_r[SPLIT_W-1:0]};
      qa5_r     <= qa4_r;
      q4_5_r    <= q4_4_r;
      neg5_r    <= neg4_r;
      qb6_r     <= prod_lo[39:DIV5_LO_SH];
      qa6_r     <= qa5_r;
      q4_6_r    <= q4_5_r;
      neg6_r    <= neg5_r;
      new7_r    <= new7;
      new8_r    <= new7_r;
      var8_r    <= diff_abs[31:0];
      out_new_r <= new8_r;
      out_var_r <= var8_r;
    end
  end

  assign out_valid     = v_r[NSTAGE];
  assign new_value     = out_new_r;
  assign variation     = out_var_r;
  assign max_variation = max_r;
  assign updated       = (ctl_r[NSTAGE].kind != K_PASS);
  assign row_end       = ctl_r[NSTAGE].row_end;

endmodule

// File: rtl/core/flow_stencil_propagation.sv
// Flow stencil propagation: streaming top level with the row-length register.
//
// Cells of the previous flow grid enter on the in_ channel in raster order,
// one request per cell, and the block returns exactly one result request per
// cell on the out_ channel, in the same order. in_tuser[1] marks the first
// cell of a sweep and clears the column position and the running maximum.
// cfg_wr_data sets the row length; write it only while the block is idle.
// Lengths below 2 act as 2 and lengths above 1024 act as 1024.
// A new cell can be taken every clock cycle while the receiver is ready.
// The front end reads two line-store entries and writes one per cell, and
// the back end is a nine-stage pipeline with a split reciprocal multiply
// for the divide by five. When out_tready is low the back end holds its
// output, the two-entry queue fills, and in_tready then drops.
// Reset clears the column position, the first-row flag, the running
// maximum and all valid flags; the row length returns to 1024. The line
// store is not cleared: the first row of every sweep refills it.
module flow_stencil_propagation import fsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,    // [31:0] cell_value
  input  logic [1:0]        in_tuser,    // [0] has_particle, [1] frame_start
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [95:0]       out_tdata,   // [31:0] new_value, [63:32] variation,
                                         // [95:64] max_variation
  output logic [0:0]        out_tuser,   // [0] updated
  output logic              out_tlast,   // row_end
  input  logic              cfg_wr_en,
  input  logic [RL_W-1:0]   cfg_wr_data  // row_length
);

  logic [RL_W-1:0]   row_length_r;
  logic              q_in_valid, q_in_ready;
  entry_t            q_in_entry;
  logic              q_out_valid, q_out_ready;
  entry_t            q_out_entry;
  logic [DATA_W-1:0] new_value, variation, max_variation;
  logic              updated;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= RL_W'(MAX_ROW_LENGTH);
    end else if (cfg_wr_en) begin
      row_length_r <= cfg_wr_data;
    end
  end

  fsp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_length   (row_length_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .cell_value   (in_tdata),
    .has_particle (in_tuser[0]),
    .frame_start  (in_tuser[1]),
    .push_valid   (q_in_valid),
    .push_ready   (q_in_ready),
    .push_entry   (q_in_entry)
  );

  fsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_entry  (q_in_entry),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_entry (q_out_entry)
  );

  fsp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (q_out_valid),
    .pop_ready     (q_out_ready),
    .pop_entry     (q_out_entry),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .new_value     (new_value),
    .variation     (variation),
    .max_variation (max_variation),
    .updated       (updated),
    .row_end       (out_tlast)
  );

  assign out_tdata    = {max_variation, variation, new_value};
  assign out_tuser[0] = updated;

endmodule

// File: tb/flow_stencil_checker.sv
// Checker for the flow stencil block: predicts each cell result and compares it with the output.
`timescale 1ns / 100ps
module flow_stencil_checker import fsp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [31:0]       in_tdata,     // [31:0] cell_value
  input  logic [1:0]        in_tuser,     // [0] has_particle, [1] frame_start
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [95:0]       out_tdata,    // [31:0] new_value, [63:32] variation,
                                          // [95:64] max_variation
  input  logic [0:0]        out_tuser,    // [0] updated
  input  logic              out_tlast,    // row_end
  input  logic              cfg_wr_en,
  input  logic [RL_W-1:0]   cfg_wr_data,  // row_length
  output int                pending,
  output int                errors
);

  typedef struct {
    logic [DATA_W-1:0] new_value;
    logic [DATA_W-1:0] variation;
    logic [DATA_W-1:0] max_variation;
    logic              updated;
    logic              row_end;
  } cell_result_t;

  cell_result_t      due_results[$];
  cell_result_t      oldest;
  logic [DATA_W-1:0] upper_row [MAX_ROW_LENGTH];
  logic [DATA_W-1:0] diag_hold;
  int unsigned       column;
  bit                first_row;
  logic [DATA_W-1:0] peak_change;
  logic [RL_W-1:0]   row_len;

  function automatic longint widen(input logic [DATA_W-1:0] x);
    return longint'($signed(x));
  endfunction

  function automatic int check_field(input string name, input logic [DATA_W-1:0] want_v,
                                     input logic [DATA_W-1:0] got);
    if (got !== want_v) begin
      $display("%0t: %s expected %h got %h", $time, name, want_v, got);
      return 1;
    end
    return 0;
  endfunction

  // Applies the weighted stencil to one cell and queues the result it should produce.
  task automatic relax_cell(input logic [DATA_W-1:0] cell_v, input logic particle,
                            input logic start);
    int unsigned       last_col;
    int unsigned       c;
    longint            old_v;
    longint            new_v;
    longint            acc;
    longint unsigned   change;
    logic [DATA_W-1:0] above;
    cell_result_t      r;
    if (row_len < 2)
      last_col = 1;
    else if (row_len > MAX_ROW_LENGTH)
      last_col = MAX_ROW_LENGTH - 1;
    else
      last_col = row_len - 1;
    if (start) begin
      column = 0;
      first_row = 1;
      peak_change = '0;
    end
    // A column left beyond the row end by a shrunk row length counts as the last column.
    c = (column > last_col) ? last_col : column;
    above = upper_row[c];
    old_v = widen(cell_v);
    new_v = old_v;
    r.updated = 1'b0;
    if (!first_row && !particle) begin
      acc = old_v + 2 * widen(above);
      if (c == 0) begin
        acc += widen(upper_row[c + 1]);
        new_v = acc / 4;
      end else if (c == last_col) begin
        acc += widen(diag_hold);
        new_v = acc / 4;
      end else begin
        acc += widen(diag_hold) + widen(upper_row[c + 1]);
        new_v = acc / 5;
      end
      r.updated = 1'b1;
    end
    change = (old_v >= new_v) ? old_v - new_v : new_v - old_v;
    if (change > peak_change)
      peak_change = change[DATA_W-1:0];
    upper_row[c] = cell_v;
    diag_hold = above;
    if (c == last_col) begin
      column = 0;
      first_row = 0;
    end else begin
      column = c + 1;
    end
    r.new_value = new_v[DATA_W-1:0];
    r.variation = change[DATA_W-1:0];
    r.max_variation = peak_change;
    r.row_end = (c == last_col);
    due_results.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      due_results.delete();
      diag_hold = '0;
      column = 0;
      first_row = 1;
      peak_change = '0;
      row_len = MAX_ROW_LENGTH;
      errors = 0;
    end else begin
      if (cfg_wr_en)
        row_len = cfg_wr_data;
      if (in_tvalid && in_tready)
        relax_cell(in_tdata, in_tuser[0], in_tuser[1]);
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, got data %h user %b last %b",
                   $time, out_tdata, out_tuser, out_tlast);
          errors++;
        end else begin
          oldest = due_results.pop_front();
          errors += check_field("new_value", oldest.new_value, out_tdata[31:0]);
          errors += check_field("variation", oldest.variation, out_tdata[63:32]);
          errors += check_field("max_variation", oldest.max_variation, out_tdata[95:64]);
          errors += check_field("updated", {31'b0, oldest.updated}, {31'b0, out_tuser[0]});
          errors += check_field("row_end", {31'b0, oldest.row_end}, {31'b0, out_tlast});
        end
      end
    end
    pending = due_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the flow stencil testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module tb_top;
  import fsp_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [31:0]     in_tdata;    // [31:0] cell_value
  logic [1:0]      in_tuser;    // [0] has_particle, [1] frame_start
  logic            out_tvalid;
  logic            out_tready;
  logic [95:0]     out_tdata;   // [31:0] new_value, [63:32] variation, [95:64] max_variation
  logic [0:0]      out_tuser;   // [0] updated
  logic            out_tlast;   // row_end
  logic            cfg_wr_en;
  logic [RL_W-1:0] cfg_wr_data; // row_length
  int              pending;
  int              errors;
  bit              calm;
  int              row_eff;

  always #5 clk = ~clk;

  flow_stencil_propagation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  flow_stencil_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .pending    (pending),
    .errors     (errors)
  );

  task automatic push_cell(input logic [31:0] value, input logic particle, input logic start);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = value;
    in_tuser = {start, particle};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_length(input int value, output bit restart);
    int eff;
    wait_drained();
    eff = (value < 2) ? 2 : (value > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : value;
    cfg_wr_en = 1'b1;
    cfg_wr_data = value[RL_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    // A longer row would read line-store entries no sweep has filled, so it must restart.
    restart = (eff > row_eff) || ($urandom_range(0, 1) == 0);
    row_eff = eff;
  endtask

  function automatic logic [31:0] random_cell();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  task automatic run_sweep(input int count, input bit restart, input bit rare_starts);
    for (int i = 0; i < count; i++)
      push_cell(random_cell(), $urandom_range(0, 7) == 0,
                (i == 0 && restart) || (rare_starts && $urandom_range(0, 79) == 0));
  endtask

  // Receiver stalls in bursts until the final quiet stretch.
  initial begin
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  initial begin
    bit restart;
    int sent;
    int len_v;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    calm = 1'b0;
    row_eff = MAX_ROW_LENGTH;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    write_length(3, restart);
    // Rows of three: full-scale values on all stencil taps, then particles and small negatives.
    push_cell(32'h7FFF_FFFF, 1'b0, 1'b1);
    push_cell(32'h8000_0000, 1'b0, 1'b0);
    push_cell(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_cell(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_cell(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_cell(32'h7FFF_FFFF, 1'b0, 1'b0);
    push_cell(32'h8000_0000, 1'b0, 1'b0);
    push_cell(32'h8000_0000, 1'b0, 1'b0);
    push_cell(32'h8000_0000, 1'b0, 1'b0);
    push_cell(32'h0000_0000, 1'b0, 1'b0);
    push_cell(32'd12345, 1'b1, 1'b0);
    push_cell(-32'sd7, 1'b0, 1'b0);
    push_cell(32'd13, 1'b0, 1'b0);
    push_cell(-32'sd13, 1'b0, 1'b0);
    // Frame start in the middle of a row.
    push_cell(32'd100, 1'b0, 1'b1);
    push_cell(32'd200, 1'b0, 1'b0);
    push_cell(32'd300, 1'b0, 1'b0);
    push_cell(32'd400, 1'b0, 1'b0);
    push_cell(32'd500, 1'b0, 1'b0);

    // The row shrinks with the column past its new end; the next cell is a right edge.
    write_length(0, restart);
    run_sweep(30, 1'b0, 1'b1);
    write_length(1, restart);
    run_sweep(30, restart, 1'b1);
    write_length(2, restart);
    run_sweep(30, restart, 1'b1);

    sent = 90;
    while (sent < 270) begin
      case ($urandom_range(0, 5))
        0: len_v = $urandom_range(13, 40);
        default: len_v = $urandom_range(2, 12);
      endcase
      write_length(len_v, restart);
      n = $urandom_range(20, 50);
      run_sweep(n, restart, 1'b1);
      sent += n;
    end

    // An over-range length acts as the widest row, so these cells stay in its first row.
    write_length(2047, restart);
    run_sweep(30, restart, 1'b0);

    calm = 1'b1;
    write_length($urandom_range(2, 12), restart);
    run_sweep(60, restart, 1'b1);

    wait_drained();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
